### design/brightness_ramp_hysteresis_assert.svh
// Assertion macros for the brightness ramp controller checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BRIGHTNESS_RAMP_HYSTERESIS_ASSERT_SVH
`define BRIGHTNESS_RAMP_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BRH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define BRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/brh_pkg.sv
// Shared types and constants for the brightness ramp controller.
// No dependencies; imported by every module of the block.
package brh_pkg;

    typedef logic [7:0] level_t;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_HYST = 2'd1,
        OP_SET_CONF = 2'd2,
        OP_INCR     = 2'd3
    } brh_op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_LEVEL     = 2'd0,
        CFG_MIN_LEVEL     = 2'd1,
        CFG_RAMP_PERIOD   = 2'd2,
        CFG_DEFAULT_LEVEL = 2'd3
    } brh_cfg_idx_t;

    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers
    localparam level_t MAX_LEVEL_RST     = 8'd255;
    localparam level_t MIN_LEVEL_RST     = 8'd10;
    localparam level_t RAMP_PERIOD_RST   = 8'd10;
    localparam level_t DEFAULT_LEVEL_RST = 8'd128;

    typedef struct packed {
        logic [1:0]        opcode;
        level_t            level_value;
        level_t            hysteresis;
        logic signed [7:0] step_amount;
    } brh_in_t;

    typedef struct packed {
        level_t pwm_level;
        logic   pwm_enabled;
        level_t target_level;
        level_t configured_level;
    } brh_out_t;

    // Live configuration seen by the update logic
    typedef struct packed {
        level_t max_level;
        level_t min_level;
        level_t ramp_period;
    } brh_cfg_t;

    typedef struct packed {
        level_t target;
        level_t configured;
        level_t applied;
        logic   running;
        level_t prescale;
    } brh_state_t;

endpackage

### design/brh_cfg.sv
// Configuration register file for the brightness ramp controller.
// Depends on brh_pkg.
module brh_cfg
    import brh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  level_t               wr_data,
    output brh_cfg_t             cfg
);

    brh_cfg_t cfg_reg;

    // Write one register per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_level   <= MAX_LEVEL_RST;
            cfg_reg.min_level   <= MIN_LEVEL_RST;
            cfg_reg.ramp_period <= RAMP_PERIOD_RST;
        end
        else if (wr_en)
        begin
            case (brh_cfg_idx_t'(wr_index))
                CFG_MAX_LEVEL:     cfg_reg.max_level   <= wr_data;
                CFG_MIN_LEVEL:     cfg_reg.min_level   <= wr_data;
                CFG_RAMP_PERIOD:   cfg_reg.ramp_period <= wr_data;
                // Default level only seeds the configured level at reset,
                // and that seed is the reset constant, so drop the write.
                CFG_DEFAULT_LEVEL: ;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/brh_core.sv
// Brightness state registers and the single-pass update for one item.
// Depends on brh_pkg.
module brh_core
    import brh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  brh_in_t  item,
    input  brh_cfg_t cfg,
    output brh_out_t result
);

    brh_state_t        state_reg;
    brh_state_t        state_next;
    level_t            pre_inc;
    level_t            applied_dec;
    level_t            set_level;
    logic signed [9:0] step_ext;
    logic signed [9:0] incr_sum;

    // Clamp to max, take a drop at once and a rise only above the hysteresis
    function automatic level_t take_level(level_t value, level_t hyst,
                                          level_t cur, level_t max_lvl);
        level_t want;
        level_t rise;
        want = (value < max_lvl) ? value : max_lvl;
        rise = want - cur;
        if (want < cur)
            return want;
        else if ((want > cur) && (rise > hyst))
            return want;
        else
            return cur;
    endfunction

    assign pre_inc     = state_reg.prescale + 8'd1;
    assign applied_dec = state_reg.applied - 8'd1;
    assign step_ext    = {{2{item.step_amount[7]}}, item.step_amount};

    // Add the signed step, clamp to min first and then to max
    always_comb
    begin
        incr_sum = $signed({2'b00, state_reg.target}) + step_ext;
        if (incr_sum < $signed({2'b00, cfg.min_level}))
            incr_sum = $signed({2'b00, cfg.min_level});
        if (incr_sum > $signed({2'b00, cfg.max_level}))
            incr_sum = $signed({2'b00, cfg.max_level});
    end

    // Level handed to the configured-set path
    assign set_level = (brh_op_t'(item.opcode) == OP_INCR) ? incr_sum[7:0]
                                                            : item.level_value;

    // Next state for the item in the input register
    always_comb
    begin
        state_next = state_reg;
        case (brh_op_t'(item.opcode))
            OP_TICK:
            begin
                if ((state_reg.target != state_reg.applied) &&
                    (state_reg.target <= cfg.max_level))
                begin
                    if (pre_inc == cfg.ramp_period)
                    begin
                        if (state_reg.target > state_reg.applied)
                        begin
                            // first up-step from zero only starts the PWM
                            if ((state_reg.applied == 8'd0) && !state_reg.running)
                                state_next.running = 1'b1;
                            else
                                state_next.applied = state_reg.applied + 8'd1;
                        end
                        else if (state_reg.applied != 8'd0)
                        begin
                            state_next.applied = applied_dec;
                            if (applied_dec == 8'd0)
                                state_next.running = 1'b0;
                        end
                        state_next.prescale = 8'd0;
                    end
                    else
                    begin
                        state_next.prescale = pre_inc;
                    end
                end
                else
                begin
                    state_next.prescale = 8'd0;
                end
            end
            OP_SET_HYST:
            begin
                state_next.target = take_level(item.level_value, item.hysteresis,
                                               state_reg.target, cfg.max_level);
            end
            OP_SET_CONF, OP_INCR:
            begin
                state_next.target     = take_level(set_level, 8'd0,
                                                   state_reg.target, cfg.max_level);
                state_next.configured = state_next.target;
            end
            default: ;
        endcase
    end

    // Hold state; advance it when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.target     <= MIN_LEVEL_RST;
            state_reg.configured <= DEFAULT_LEVEL_RST;
            state_reg.applied    <= 8'd0;
            state_reg.running    <= 1'b0;
            state_reg.prescale   <= 8'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign result.pwm_level        = state_next.applied;
    assign result.pwm_enabled      = state_next.running;
    assign result.target_level     = state_next.target;
    assign result.configured_level = state_next.configured;

endmodule

### design/brightness_ramp_hysteresis.sv
// Top level of the display brightness ramp controller.
// Depends on brh_pkg, brh_cfg and brh_core.
//
// Takes one item per clock while in_stall is low and returns one result per
// item. An accepted item sits in the input register while the update logic
// computes the new brightness state; the result then lands in the output
// register and is offered from there. The output register is the only point
// of backpressure: in_stall rises only while both registers are full and the
// result is stalled. Configuration writes are always ready and take effect for
// every item that advances after the write; target and configured level start
// from their reset constants.
module brightness_ramp_hysteresis
    import brh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  brh_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output brh_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  level_t               cfg_data
);

    logic     stage_valid_reg;
    brh_in_t  stage_item_reg;
    logic     out_valid_reg;
    brh_out_t out_data_reg;
    logic     out_free;
    logic     advance;
    logic     in_xfer;
    brh_cfg_t cfg;
    brh_out_t result;

    assign cfg_ready = 1'b1;

    brh_cfg u_brh_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    brh_core u_brh_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Handshake: advance when the output register is empty or draining
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_free;
    assign in_stall = stage_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // Valid flags of the input and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers load on transfer or advance
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            stage_item_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/brh_checker.sv
// Port-level checker for the brightness ramp controller, bound to the top.
// Depends on brh_pkg and brightness_ramp_hysteresis_assert.svh.
`include "brightness_ramp_hysteresis_assert.svh"

module brh_checker
    import brh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input brh_out_t out_data
);

    // A stalled result holds
    `BRH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Input backpressure only comes from a stalled, full output
    `BRH_ASSERT_NOW(a_stall_cause, in_valid && in_stall, out_valid && out_stall, "input stalled without output stall")

    // A nonzero duty level implies the PWM is running
    `BRH_ASSERT_NOW(a_pwm_running, out_valid && (out_data.pwm_level != 8'd0), out_data.pwm_enabled, "duty level nonzero with PWM stopped")

endmodule

bind brightness_ramp_hysteresis brh_checker u_brh_checker (.*);

### verif/brightness_ramp_hysteresis_tb.sv
// Self-checking testbench for the display brightness ramp controller.
// Drives directed and random items against a cycle-free predictor of the block.
// Depends on brh_pkg and the brightness_ramp_hysteresis RTL only.
module brightness_ramp_hysteresis_tb
    import brh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    brh_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    brh_out_t   out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    level_t     cfg_data;

    // One line of the directed sequence: a register write or an item
    typedef struct {
        bit           is_cfg;
        brh_cfg_idx_t idx;
        level_t       val;
        brh_in_t      item;
        bit           typed;
        brh_out_t     want;
    } dir_row_t;

    // Predicted register copy and brightness state
    level_t max_lvl;
    level_t min_lvl;
    level_t period_lvl;
    level_t dflt_lvl;
    level_t tgt_lvl;
    level_t conf_lvl;
    level_t pwm_lvl;
    logic   pwm_on;
    level_t tick_div;

    brh_out_t pending_levels[$];
    dir_row_t dir_rows[$];

    // Typed expectation travels with the item that the sender offers
    bit       in_typed;
    brh_out_t in_typed_exp;

    bit hold_req;
    int burst_left;
    int items_sent;
    int levels_checked;
    int level_errors;
    int phases_run;

    brightness_ramp_hysteresis u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Take a set request: drop at once, rise only past the hysteresis
    function automatic void take_target(level_t value, level_t hyst);
        level_t want;
        want = (value < max_lvl) ? value : max_lvl;
        if (want < tgt_lvl)
        begin
            tgt_lvl = want;
        end
        else if (want > tgt_lvl && level_t'(want - tgt_lvl) > hyst)
        begin
            tgt_lvl = want;
        end
    endfunction

    // Advance the brightness state by one item and return the new outputs
    function automatic brh_out_t step_brightness(brh_in_t item);
        brh_out_t res;
        int       sum;
        case (brh_op_t'(item.opcode))
            OP_TICK:
            begin
                if (tgt_lvl != pwm_lvl && tgt_lvl <= max_lvl)
                begin
                    tick_div = tick_div + 8'd1;
                    if (tick_div == period_lvl)
                    begin
                        if (tgt_lvl > pwm_lvl)
                        begin
                            if (pwm_lvl == 8'd0 && !pwm_on)
                                pwm_on = 1'b1;
                            else
                                pwm_lvl = pwm_lvl + 8'd1;
                        end
                        else if (pwm_lvl != 8'd0)
                        begin
                            pwm_lvl = pwm_lvl - 8'd1;
                            if (pwm_lvl == 8'd0)
                                pwm_on = 1'b0;
                        end
                        tick_div = 8'd0;
                    end
                end
                else
                begin
                    tick_div = 8'd0;
                end
            end
            OP_SET_HYST:
            begin
                take_target(item.level_value, item.hysteresis);
            end
            OP_SET_CONF:
            begin
                take_target(item.level_value, 8'd0);
                conf_lvl = tgt_lvl;
            end
            default:
            begin
                sum = int'(tgt_lvl) + int'($signed(item.step_amount));
                if (sum < int'(min_lvl))
                    sum = int'(min_lvl);
                if (sum > int'(max_lvl))
                    sum = int'(max_lvl);
                take_target(level_t'(sum), 8'd0);
                conf_lvl = tgt_lvl;
            end
        endcase
        res.pwm_level        = pwm_lvl;
        res.pwm_enabled      = pwm_on;
        res.target_level     = tgt_lvl;
        res.configured_level = conf_lvl;
        return res;
    endfunction

    function automatic void log_error(string msg);
        level_errors++;
        if (level_errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Check results, track register writes and predict each accepted item
    always @(posedge clk)
    begin
        brh_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    log_error($sformatf("result with nothing expected: pwm %0d en %0d tgt %0d conf %0d",
                        out_data.pwm_level, out_data.pwm_enabled,
                        out_data.target_level, out_data.configured_level));
                end
                else
                begin
                    want = pending_levels.pop_front();
                    levels_checked++;
                    if (out_data.pwm_level !== want.pwm_level ||
                        out_data.pwm_enabled !== want.pwm_enabled ||
                        out_data.target_level !== want.target_level ||
                        out_data.configured_level !== want.configured_level)
                    begin
                        log_error($sformatf(
                            "result %0d: exp pwm %0d en %0d tgt %0d conf %0d, got pwm %0d en %0d tgt %0d conf %0d",
                            levels_checked, want.pwm_level, want.pwm_enabled,
                            want.target_level, want.configured_level,
                            out_data.pwm_level, out_data.pwm_enabled,
                            out_data.target_level, out_data.configured_level));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (brh_cfg_idx_t'(cfg_index))
                    CFG_MAX_LEVEL:   max_lvl    = cfg_data;
                    CFG_MIN_LEVEL:   min_lvl    = cfg_data;
                    CFG_RAMP_PERIOD: period_lvl = cfg_data;
                    default:         dflt_lvl   = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                items_sent++;
                want = step_brightness(in_data);
                if (in_typed)
                    want = in_typed_exp;
                pending_levels.push_back(want);
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus long hold-offs
    initial
    begin
        int mode;
        int mode_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(3, 0);
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            case (mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(3, 0) == 0);
                2:       out_stall = ($urandom_range(9, 0) < 6);
                default: out_stall = (cyc % 3 == 0);
            endcase
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("brightness_ramp_hysteresis_tb NOT OK");
        $finish;
    end

    function automatic dir_row_t drow(brh_op_t op, level_t lvl, level_t hy, int st, bit typed,
                                      level_t pw, logic en, level_t tg, level_t cf);
        dir_row_t r;
        r.is_cfg                = 1'b0;
        r.idx                   = CFG_MAX_LEVEL;
        r.val                   = 8'd0;
        r.item.opcode           = op;
        r.item.level_value      = lvl;
        r.item.hysteresis       = hy;
        r.item.step_amount      = st[7:0];
        r.typed                 = typed;
        r.want.pwm_level        = pw;
        r.want.pwm_enabled      = en;
        r.want.target_level     = tg;
        r.want.configured_level = cf;
        return r;
    endfunction

    function automatic dir_row_t crow(brh_cfg_idx_t idx, level_t val);
        dir_row_t r;
        r        = drow(OP_TICK, 8'd0, 8'd0, 0, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic brh_in_t random_item(int unsigned tick_pct);
        brh_in_t     it;
        int unsigned pick;
        int          s;
        it.level_value = level_t'($urandom_range(255, 0));
        if ($urandom_range(1, 0) == 1)
            it.hysteresis = level_t'($urandom_range(15, 0));
        else
            it.hysteresis = level_t'($urandom_range(255, 0));
        if ($urandom_range(1, 0) == 1)
            s = int'($urandom_range(16, 0)) - 8;
        else
            s = int'($urandom_range(255, 0));
        it.step_amount = s[7:0];
        pick = $urandom_range(99, 0);
        if (pick < tick_pct)
            it.opcode = OP_TICK;
        else
        begin
            case (pick % 4)
                0, 1:    it.opcode = OP_SET_HYST;
                2:       it.opcode = OP_SET_CONF;
                default: it.opcode = OP_INCR;
            endcase
        end
        return it;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(brh_in_t item, bit typed, brh_out_t want);
        @(negedge clk);
        in_valid     = 1'b1;
        in_data      = item;
        in_typed     = typed;
        in_typed_exp = want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Idle the sender between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(6, 0);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(brh_cfg_idx_t idx, level_t val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        level_t      mx;
        level_t      mn;
        level_t      per;
        level_t      dfl;
        int unsigned tick_pct;
        brh_out_t    none;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_typed     = 1'b0;
        in_typed_exp = '0;
        none         = '0;
        hold_req     = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        levels_checked = 0;
        level_errors = 0;
        phases_run   = 0;

        max_lvl    = MAX_LEVEL_RST;
        min_lvl    = MIN_LEVEL_RST;
        period_lvl = RAMP_PERIOD_RST;
        dflt_lvl   = DEFAULT_LEVEL_RST;
        tgt_lvl    = MIN_LEVEL_RST;
        conf_lvl   = DEFAULT_LEVEL_RST;
        pwm_lvl    = 8'd0;
        pwm_on     = 1'b0;
        tick_div   = 8'd0;

        // Reset state, field extremes and unused fields at zero, all ones and alternating bits
        dir_rows.push_back(drow(OP_TICK,     8'd0,   8'd0,   0,    1, 0, 0, 10,  128));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd255, 8'd255, 0,    1, 0, 0, 10,  128));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd255, 8'd0,   0,    1, 0, 0, 255, 128));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd0,   8'd255, -1,   1, 0, 0, 0,   128));
        dir_rows.push_back(drow(OP_INCR,     8'd255, 8'd255, -128, 1, 0, 0, 10,  10));
        dir_rows.push_back(drow(OP_INCR,     8'd0,   8'd0,   127,  1, 0, 0, 137, 137));
        dir_rows.push_back(drow(OP_SET_CONF, 8'd255, 8'hAA,  85,   1, 0, 0, 255, 255));
        dir_rows.push_back(drow(OP_SET_CONF, 8'd0,   8'h55,  -86,  1, 0, 0, 0,   0));
        dir_rows.push_back(drow(OP_TICK,     8'd255, 8'd255, -1,   1, 0, 0, 0,   0));
        // Fast ramp: start PWM from zero, up-step from zero while running, ramp down
        dir_rows.push_back(crow(CFG_RAMP_PERIOD, 8'd1));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd2, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd2, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_TICK,     8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
        // Target above max holds the ramp; min above max clamps to max
        dir_rows.push_back(drow(OP_SET_CONF, 8'd200, 8'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(crow(CFG_MAX_LEVEL, 8'd5));
        dir_rows.push_back(crow(CFG_MIN_LEVEL, 8'd200));
        dir_rows.push_back(drow(OP_TICK,     8'd0,   8'd0, 0,    1, 0, 0, 200, 200));
        dir_rows.push_back(drow(OP_INCR,     8'd0,   8'd0, 1,    1, 0, 0, 5,   5));
        dir_rows.push_back(drow(OP_SET_HYST, 8'd255, 8'd0, 0,    1, 0, 0, 5,   5));
        dir_rows.push_back(drow(OP_INCR,     8'd0,   8'd0, -128, 1, 0, 0, 5,   5));

        // Hold reset, then release between edges
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                wait_idle();
                write_cfg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
                pace_sender();
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tick_pct = 65;
            case (p)
                0:
                begin
                    mx = 8'd255; mn = 8'd0; per = 8'd1; dfl = 8'd0;
                end
                1:
                begin
                    mx = MAX_LEVEL_RST; mn = MIN_LEVEL_RST;
                    per = RAMP_PERIOD_RST; dfl = DEFAULT_LEVEL_RST;
                end
                2:
                begin
                    // Period zero wraps the prescaler every 256 ticks
                    mx = 8'd200; mn = 8'd50; per = 8'd0; dfl = 8'd255;
                    tick_pct = 95;
                end
                3:
                begin
                    mx = 8'd0; mn = 8'd255; per = 8'd255; dfl = 8'd77;
                end
                default:
                begin
                    mx  = level_t'($urandom_range(255, 60));
                    mn  = level_t'($urandom_range(120, 0));
                    per = level_t'($urandom_range(12, 1));
                    dfl = level_t'($urandom_range(255, 0));
                end
            endcase
            wait_idle();
            write_cfg(CFG_MAX_LEVEL, mx);
            write_cfg(CFG_MIN_LEVEL, mn);
            write_cfg(CFG_RAMP_PERIOD, per);
            write_cfg(CFG_DEFAULT_LEVEL, dfl);
            phases_run++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((p == 1 || p == 5) && n == ITEMS_PER_PHASE / 2)
                begin
                    // Back up the output while the sender keeps offering, then drain
                    hold_req = 1'b1;
                    repeat (30) send_item(random_item(tick_pct), 1'b0, none);
                    wait_idle();
                end
                send_item(random_item(tick_pct), 1'b0, none);
                pace_sender();
            end
        end

        // Drain and let any stray result show up
        wait_idle();
        repeat (10) @(negedge clk);

        $display("Ran %0d items through %0d register settings; %0d results checked, %0d mismatches.",
                 items_sent, phases_run + 1, levels_checked, level_errors);
        if (pending_levels.size() != 0)
            $display("ERROR: %0d expected results never arrived", pending_levels.size());
        if (level_errors == 0 && pending_levels.size() == 0)
        begin
            $display("brightness_ramp_hysteresis_tb OK");
        end
        else
        begin
            $display("brightness_ramp_hysteresis_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/brh_pkg.sv
design/brh_cfg.sv
design/brh_core.sv
design/brightness_ramp_hysteresis.sv
design/brh_checker.sv
verif/brightness_ramp_hysteresis_tb.sv
